[sv/phs_pkg.sv]
// Shared types and constants for the pipeline hazard scoreboard.
`default_nettype none
package phs_pkg;

    localparam int AGE_W = 3;
    localparam int REG_W = 5;
    localparam int CLS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CLS_W-1:0] CLS_ALU_REG = 3'd0;
    localparam logic [CLS_W-1:0] CLS_ALU_IMM = 3'd1;
    localparam logic [CLS_W-1:0] CLS_LOAD    = 3'd2;
    localparam logic [CLS_W-1:0] CLS_STORE   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_BRANCH  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ISSUE_AGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_AGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_AGE = 2'd2;

    localparam logic [AGE_W-1:0] ISSUE_AGE_RST  = 3'd2;
    localparam logic [AGE_W-1:0] READY_AGE_RST  = 3'd5;
    localparam logic [AGE_W-1:0] EXPIRE_AGE_RST = 3'd6;

    typedef struct packed {
        logic             valid_req;
        logic [CLS_W-1:0] instr_class;
        logic [REG_W-1:0] dest_reg;
        logic [REG_W-1:0] src_a;
        logic [REG_W-1:0] src_b;
    } phs_in_t;

    typedef struct packed {
        logic stall_res;
        logic issued;
    } phs_out_t;

endpackage
`default_nettype wire

[sv/pipeline_hazard_scoreboard_top.sv]
// Top level of the decode-stage register hazard scoreboard.
`default_nettype none
// Each transfer on the s_ channel is one decode cycle: its sources are checked against the
// scoreboard, the destination of an issuing instruction other than a store or branch is marked
// busy, and every busy entry ages by one, all in the cycle of the transfer. The result is one
// stall/issued pair per transfer, held in an output register. The block takes one item per
// clock; only reset or a result in the output register that m_ready has not yet taken holds
// s_ready low. Reset clears the scoreboard; configuration writes take effect on the next item.
module pipeline_hazard_scoreboard_top #(
    parameter int NUM_REGS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire phs_pkg::phs_in_t                s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output phs_pkg::phs_out_t                    m_data,
    input  wire logic                            cfg_wen,
    input  wire logic [phs_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [phs_pkg::AGE_W-1:0]       cfg_wdata
);
    import phs_pkg::*;

    logic [AGE_W-1:0] issue_age_reg;
    logic [AGE_W-1:0] ready_age_reg;
    logic [AGE_W-1:0] expire_age_reg;

    logic [NUM_REGS-1:0] busy_flag_reg;
    logic [NUM_REGS-1:0] busy_flag_next;
    logic [AGE_W-1:0]    busy_age_reg  [NUM_REGS];
    logic [AGE_W-1:0]    busy_age_next [NUM_REGS];

    logic     m_valid_reg;
    phs_out_t m_data_reg;
    phs_out_t res_next;

    logic                s_accept;
    logic [NUM_REGS-1:0] block_vec;
    logic [NUM_REGS-1:0] a_hit;
    logic [NUM_REGS-1:0] b_hit;
    logic [NUM_REGS-1:0] d_hit;
    logic                known_cls;
    logic                chk_b;
    logic                hazard;
    logic                mark_en;

    assign s_ready  = aresetn && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        logic             flag1;
        logic [AGE_W-1:0] age1;
        logic [AGE_W:0]   age_inc;

        flag1   = 1'b0;
        age1    = '0;
        age_inc = '0;

        // Every entry produces its own "still blocking" bit; the sources pick from that vector.
        for (int i = 0; i < NUM_REGS; i++) begin
            block_vec[i] = busy_flag_reg[i] && (busy_age_reg[i] < ready_age_reg);
            a_hit[i]     = (32'(s_data.src_a) == 32'(i));
            b_hit[i]     = (32'(s_data.src_b) == 32'(i));
            d_hit[i]     = (32'(s_data.dest_reg) == 32'(i));
        end

        known_cls = s_data.valid_req && (s_data.instr_class <= CLS_BRANCH);
        chk_b     = s_data.instr_class inside {CLS_ALU_REG, CLS_STORE, CLS_BRANCH};
        hazard    = (|(a_hit & block_vec)) || (chk_b && (|(b_hit & block_vec)));

        res_next.stall_res = known_cls && hazard;
        res_next.issued    = known_cls && !hazard;
        mark_en = res_next.issued && !(s_data.instr_class inside {CLS_STORE, CLS_BRANCH});

        // Marking happens before aging, so a fresh entry already ages in its issue cycle.
        for (int i = 0; i < NUM_REGS; i++) begin
            flag1   = busy_flag_reg[i] || (mark_en && d_hit[i]);
            age1    = (mark_en && d_hit[i]) ? issue_age_reg : busy_age_reg[i];
            age_inc = {1'b0, age1} + {{AGE_W{1'b0}}, 1'b1};
            if (flag1 && (age_inc < {1'b0, expire_age_reg})) begin
                busy_flag_next[i] = 1'b1;
                busy_age_next[i]  = age_inc[AGE_W-1:0];
            end else begin
                busy_flag_next[i] = 1'b0;
                busy_age_next[i]  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_age_reg  <= ISSUE_AGE_RST;
            ready_age_reg  <= READY_AGE_RST;
            expire_age_reg <= EXPIRE_AGE_RST;
        end else if (cfg_wen) begin
            case (cfg_idx)
                CFG_ISSUE_AGE:  issue_age_reg  <= cfg_wdata;
                CFG_READY_AGE:  ready_age_reg  <= cfg_wdata;
                CFG_EXPIRE_AGE: expire_age_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_flag_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                busy_flag_reg <= busy_flag_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Ages are meaningful only while the matching busy flag is set.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            busy_age_reg <= busy_age_next;
            m_data_reg   <= res_next;
        end
    end

    a_stall_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.stall_res && m_data.issued))
        else $error("stall and issue reported together");

    a_bubble_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_data.valid_req |=> m_valid && !m_data.stall_res && !m_data.issued)
        else $error("empty decode slot produced a stall or issue");

    a_no_mark_store: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_data.instr_class == CLS_STORE || s_data.instr_class == CLS_BRANCH)
        |=> $countones(busy_flag_reg) <= $past($countones(busy_flag_reg)))
        else $error("store or branch marked a register busy");

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the decode-stage register hazard scoreboard.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import phs_pkg::*;

    localparam int NUM_REGS       = 32;
    localparam int RANDOM_PER_SET = 40;
    localparam int MAX_GAP        = 16;
    localparam int LONG_HOLD_AT   = 180;
    localparam int LONG_HOLD_LEN  = 80;
    localparam int QUIET_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    phs_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    phs_out_t m_data;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_ISSUE_AGE;
    logic [AGE_W-1:0]     cfg_wdata = '0;

    pipeline_hazard_scoreboard_top #(
        .NUM_REGS(NUM_REGS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wen(cfg_wen),
        .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    // Scoreboard copy kept by the testbench, plus the live age settings.
    logic             sb_busy [NUM_REGS];
    logic [AGE_W-1:0] sb_age [NUM_REGS];
    logic [AGE_W-1:0] cfg_issue_age  = ISSUE_AGE_RST;
    logic [AGE_W-1:0] cfg_ready_age  = READY_AGE_RST;
    logic [AGE_W-1:0] cfg_expire_age = EXPIRE_AGE_RST;

    phs_in_t  instr_pending_q[$];
    phs_out_t stall_expect_q[$];
    int       mismatch_cnt = 0;
    bit       s_idle_on = 1'b0;
    bit       m_idle_on = 1'b0;
    int       s_gap_left = 0;
    int       m_wait_left = 0;
    int       m_hold_left = 0;
    int       results_seen = 0;
    int       quiet_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic reg_blocks(logic [REG_W-1:0] r);
        if (r >= NUM_REGS)
            return 1'b0;
        return sb_busy[r] && (sb_age[r] < cfg_ready_age);
    endfunction

    // One decode cycle: check sources against the old state, mark, then age everything.
    function automatic phs_out_t score_decode(phs_in_t instr);
        phs_out_t    res;
        logic        hazard;
        logic [AGE_W:0] next_age;
        res = '0;
        if (instr.valid_req && instr.instr_class <= CLS_BRANCH) begin
            hazard = reg_blocks(instr.src_a);
            if (instr.instr_class == CLS_ALU_REG || instr.instr_class == CLS_STORE ||
                instr.instr_class == CLS_BRANCH)
                hazard = hazard || reg_blocks(instr.src_b);
            if (hazard) begin
                res.stall_res = 1'b1;
            end else begin
                res.issued = 1'b1;
                if (instr.instr_class != CLS_STORE && instr.instr_class != CLS_BRANCH &&
                    instr.dest_reg < NUM_REGS) begin
                    sb_busy[instr.dest_reg] = 1'b1;
                    sb_age[instr.dest_reg] = cfg_issue_age;
                end
            end
        end
        for (int r = 0; r < NUM_REGS; r++) begin
            if (sb_busy[r]) begin
                next_age = {1'b0, sb_age[r]} + {{AGE_W{1'b0}}, 1'b1};
                if (next_age >= {1'b0, cfg_expire_age}) begin
                    sb_busy[r] = 1'b0;
                    sb_age[r] = '0;
                end else begin
                    sb_age[r] = next_age[AGE_W-1:0];
                end
            end
        end
        return res;
    endfunction

    // Registers come mostly from a small pool so that hazards actually occur.
    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(0, 3) == 0)
            return REG_W'($urandom);
        return REG_W'($urandom_range(0, 3));
    endfunction

    function automatic phs_in_t rand_instr();
        phs_in_t it;
        it.valid_req = 1'b1;
        it.instr_class = CLS_W'($urandom_range(CLS_ALU_REG, CLS_BRANCH));
        it.dest_reg = pick_reg();
        it.src_a = pick_reg();
        it.src_b = pick_reg();
        case ($urandom_range(0, 19))
            0: it.valid_req = 1'b0;
            1: it.instr_class = CLS_W'($urandom_range(CLS_BRANCH + 1, (1 << CLS_W) - 1));
            default: ;
        endcase
        return it;
    endfunction

    task automatic push_instr(logic v, logic [CLS_W-1:0] c, logic [REG_W-1:0] d,
                              logic [REG_W-1:0] a, logic [REG_W-1:0] b);
        phs_in_t it;
        it = '{valid_req: v, instr_class: c, dest_reg: d, src_a: a, src_b: b};
        instr_pending_q.push_back(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AGE_W-1:0] val);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ISSUE_AGE:  cfg_issue_age = val;
            CFG_READY_AGE:  cfg_ready_age = val;
            CFG_EXPIRE_AGE: cfg_expire_age = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Waits until no item is queued, offered, computed or waiting at the output.
    task automatic drain();
        while (instr_pending_q.size() != 0 || stall_expect_q.size() != 0 || s_valid || m_valid)
            @(negedge aclk);
    endtask

    task automatic run_setting(logic [AGE_W-1:0] iss, logic [AGE_W-1:0] rdy,
                               logic [AGE_W-1:0] expv);
        int counted;
        phs_in_t it;
        counted = 0;
        drain();
        write_reg(CFG_ISSUE_AGE, iss);
        write_reg(CFG_READY_AGE, rdy);
        write_reg(CFG_EXPIRE_AGE, expv);
        @(negedge aclk);
        s_idle_on = ($urandom_range(0, 3) != 0);
        m_idle_on = ($urandom_range(0, 3) != 0);
        while (counted < RANDOM_PER_SET) begin
            it = rand_instr();
            instr_pending_q.push_back(it);
            if (it.valid_req && it.instr_class <= CLS_BRANCH)
                counted++;
        end
    endtask

    initial begin
        for (int r = 0; r < NUM_REGS; r++) begin
            sb_busy[r] = 1'b0;
            sb_age[r] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pass at the reset settings.
        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
        push_instr(1'b0, CLS_ALU_REG, 5'd31, 5'd31, 5'd31);
        push_instr(1'b1, CLS_BRANCH + 3'd1, 5'd1, 5'd0, 5'd0);
        push_instr(1'b1, CLS_BRANCH + 3'd2, 5'd2, 5'd0, 5'd0);
        push_instr(1'b1, CLS_BRANCH + 3'd3, 5'd3, 5'd0, 5'd0);
        push_instr(1'b1, CLS_ALU_REG, 5'd1, 5'd0, 5'd0);
        push_instr(1'b1, CLS_ALU_REG, 5'd4, 5'd1, 5'd0);
        push_instr(1'b1, CLS_ALU_REG, 5'd4, 5'd0, 5'd1);
        push_instr(1'b1, CLS_ALU_IMM, 5'd2, 5'd0, 5'd1);
        push_instr(1'b1, CLS_LOAD, 5'd3, 5'd2, 5'd1);
        push_instr(1'b1, CLS_LOAD, 5'd3, 5'd0, 5'd2);
        push_instr(1'b1, CLS_STORE, 5'd5, 5'd0, 5'd3);
        push_instr(1'b1, CLS_STORE, 5'd1, 5'd31, 5'd0);
        push_instr(1'b1, CLS_BRANCH, 5'd6, 5'd3, 5'd0);
        push_instr(1'b1, CLS_BRANCH, 5'd6, 5'd0, 5'd3);
        push_instr(1'b1, CLS_ALU_REG, 5'd31, 5'd31, 5'd31);
        push_instr(1'b1, CLS_ALU_REG, 5'd31, 5'd31, 5'd31);
        push_instr(1'b0, CLS_ALU_REG, 5'd0, 5'd0, 5'd0);
        push_instr(1'b1, CLS_ALU_IMM, 5'd31, 5'd31, 5'd0);
        push_instr(1'b1, CLS_LOAD, 5'd0, 5'd31, 5'd31);
        push_instr(1'b1, CLS_ALU_REG, 5'd0, 5'd0, 5'd31);
        push_instr(1'b1, CLS_ALU_REG, 5'd10, 5'd0, 5'd0);
        for (int k = 0; k < RANDOM_PER_SET; k++)
            instr_pending_q.push_back(rand_instr());

        run_setting(3'd0, 3'd7, 3'd7);
        run_setting(3'd7, 3'd7, 3'd7);
        run_setting(3'd0, 3'd0, 3'd1);
        run_setting(3'd3, 3'd7, 3'd0);
        run_setting(3'd5, 3'd6, 3'd3);
        run_setting(ISSUE_AGE_RST, READY_AGE_RST, EXPIRE_AGE_RST);
        run_setting(AGE_W'($urandom), AGE_W'($urandom), AGE_W'($urandom_range(1, 7)));
        run_setting(AGE_W'($urandom), AGE_W'($urandom), AGE_W'($urandom_range(1, 7)));

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Instruction driver: the model is advanced at the edge where a transfer happens.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                stall_expect_q.push_back(score_decode(s_data));
            if (!s_valid || s_ready) begin
                if (s_gap_left > 0) begin
                    s_gap_left--;
                    s_valid <= 1'b0;
                end else if (instr_pending_q.size() != 0) begin
                    s_data <= instr_pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_gap_left = s_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure, including one long hold-off.
    always @(posedge aclk) begin
        phs_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (stall_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("result %0d with nothing expected: stall=%0b issued=%0b",
                                 results_seen, m_data.stall_res, m_data.issued);
                end else begin
                    want = stall_expect_q.pop_front();
                    if (m_data.stall_res !== want.stall_res || m_data.issued !== want.issued) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("result %0d: expected stall=%0b issued=%0b, got %0b %0b",
                                     results_seen, want.stall_res, want.issued,
                                     m_data.stall_res, m_data.issued);
                    end
                end
                results_seen++;
                if (results_seen == LONG_HOLD_AT)
                    m_hold_left = LONG_HOLD_LEN;
                m_wait_left = m_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end else if (m_hold_left > 0) begin
                m_hold_left--;
            end else if (m_wait_left > 0) begin
                m_wait_left--;
            end
            m_ready <= (m_hold_left == 0 && m_wait_left == 0);
        end
    end

    // A stretch with no transfer on either channel means the block has hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
`default_nettype wire

[filelist.f]
sv/phs_pkg.sv
sv/pipeline_hazard_scoreboard_top.sv
sim/testbench.sv
